[hw/rtl/sdp_pkg.sv]
// sdp_pkg: shared widths, constants, register indexes and types for the
// sph density / pressure core. Used by every rtl file of the block.
// No dependencies.
package sdp_pkg;

  localparam int POS_WIDTH = 24;
  localparam int POS_FRAC  = 12;

  localparam int DIFF_W = POS_WIDTH + 1;
  localparam int SQ_W   = 2 * POS_WIDTH + 1;
  localparam int SUM_W  = SQ_W + 2;
  localparam int SHL    = (2 * POS_FRAC < 24) ? 24 - 2 * POS_FRAC : 0;
  localparam int SHR    = (2 * POS_FRAC > 24) ? 2 * POS_FRAC - 24 : 0;
  localparam int R2_W   = SUM_W + SHL;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 8;
  localparam int ACC_W     = 40;
  localparam int DENS_W    = 32;
  localparam int PRES_W    = 48;
  localparam int T2_W      = 40;
  localparam int T3_W      = 48;
  localparam int PP_W      = 56;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ        = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COEF      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_REST_DENSITY = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BULK_MODULUS     = 8'd3;

  localparam logic [CFG_W-1:0] RADIUS_SQ_RST        = 32'd16777216;
  localparam logic [CFG_W-1:0] KERNEL_COEF_RST      = 32'd1026740;
  localparam logic [CFG_W-1:0] INV_REST_DENSITY_RST = 32'd4307891;
  localparam logic [CFG_W-1:0] BULK_MODULUS_RST     = 32'd2200000000;

  localparam logic [ACC_W-1:0]  ACC_MAX    = '1;
  localparam logic [DENS_W-1:0] DENS_MAX   = '1;
  localparam logic [DENS_W-1:0] DENS_FLOOR = 32'd6554;
  localparam logic [PRES_W-1:0] PRES_MAX   = '1;
  localparam logic [PRES_W-1:0] PRES_FLOOR = 48'd26;
  localparam logic [PRES_W-1:0] ONE_Q24    = 48'h1000000;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // exponent of the tait law; step 0 is the ratio, steps 1..POW_EXP-1 the powers
  localparam int POW_EXP = 7;
  localparam int STEP_W  = $clog2(POW_EXP + 1);
  localparam logic [STEP_W-1:0] STEP_RATIO = '0;
  localparam logic [STEP_W-1:0] STEP_PRES  = STEP_W'(POW_EXP);

  typedef struct packed {
    logic [CFG_W-1:0] t;
    logic             last;
  } dist_t;

  typedef struct packed {
    logic [ACC_W-1:0] w;
    logic             last;
  } entry_t;

  typedef enum logic [2:0] {
    BK_ACC,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_MUL_SUM,
    BK_OUT
  } back_state_t;

endpackage

[hw/rtl/sdp_ifs.sv]
// sdp_ifs: valid/ready channel interfaces of the sph density / pressure core
// (neighbor records, results, register writes). Depends on sdp_pkg.
interface sdp_rec_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sdp_pkg::POS_WIDTH-1:0]  center_x;
  logic signed [sdp_pkg::POS_WIDTH-1:0]  center_y;
  logic signed [sdp_pkg::POS_WIDTH-1:0]  center_z;
  logic signed [sdp_pkg::POS_WIDTH-1:0]  neighbor_x;
  logic signed [sdp_pkg::POS_WIDTH-1:0]  neighbor_y;
  logic signed [sdp_pkg::POS_WIDTH-1:0]  neighbor_z;
  logic                                  is_self;
  logic                                  last;

  modport source (
    output valid, center_x, center_y, center_z,
    output neighbor_x, neighbor_y, neighbor_z, is_self, last,
    input  ready
  );
  modport sink (
    input  valid, center_x, center_y, center_z,
    input  neighbor_x, neighbor_y, neighbor_z, is_self, last,
    output ready
  );
endinterface

interface sdp_res_if;
  logic                          valid;
  logic                          ready;
  logic [sdp_pkg::DENS_W-1:0]    density;
  logic [sdp_pkg::PRES_W-1:0]    pressure;

  modport source (output valid, density, pressure, input ready);
  modport sink (input valid, density, pressure, output ready);
endinterface

interface sdp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sdp_pkg::CFG_IDX_W-1:0]    index;
  logic [sdp_pkg::CFG_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/sdp_front.sv]
// sdp_front: accepts neighbor records and classifies them: position
// differences, squared distance, range test against the radius.
// Depends on sdp_pkg and sdp_ifs.
module sdp_front (
  input  logic                        clk,
  input  logic                        rst,
  sdp_rec_if.sink                     rec,
  input  logic [sdp_pkg::CFG_W-1:0]   radius_sq,
  output logic                        dist_valid,
  input  logic                        dist_ready,
  output sdp_pkg::dist_t              dist_data
);

  logic [3:0] v;
  logic [3:0] en;

  logic signed [sdp_pkg::DIFF_W-1:0]   dx, dy, dz;
  logic signed [2*sdp_pkg::DIFF_W-1:0] px, py, pz;
  logic [sdp_pkg::SQ_W-1:0]            sqx, sqy, sqz;
  logic [sdp_pkg::SUM_W-1:0]           sum;
  logic [sdp_pkg::R2_W-1:0]            r2w;
  logic [sdp_pkg::CFG_W-1:0]           r2lo;
  logic                                r2_small;
  logic                                hit;
  logic                                self1, self2, self3;
  logic                                last1, last2, last3;
  sdp_pkg::dist_t                      dist_q;

  always_comb begin
    en[3] = !v[3] || dist_ready;
    en[2] = !v[2] || en[3];
    en[1] = !v[1] || en[2];
    en[0] = !v[0] || en[1];
  end

  assign rec.ready  = en[0];
  assign dist_valid = v[3];
  assign dist_data  = dist_q;

  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  assign r2w      = (sdp_pkg::R2_W'(sum) << sdp_pkg::SHL) >> sdp_pkg::SHR;
  assign r2_small = (r2w >> sdp_pkg::CFG_W) == '0;
  assign r2lo     = r2w[sdp_pkg::CFG_W-1:0];
  assign hit      = !self3 && r2_small && (r2lo < radius_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= rec.valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx    <= sdp_pkg::DIFF_W'(rec.center_x) - sdp_pkg::DIFF_W'(rec.neighbor_x);
      dy    <= sdp_pkg::DIFF_W'(rec.center_y) - sdp_pkg::DIFF_W'(rec.neighbor_y);
      dz    <= sdp_pkg::DIFF_W'(rec.center_z) - sdp_pkg::DIFF_W'(rec.neighbor_z);
      self1 <= rec.is_self;
      last1 <= rec.last;
    end
    if (en[1]) begin
      sqx   <= px[sdp_pkg::SQ_W-1:0];
      sqy   <= py[sdp_pkg::SQ_W-1:0];
      sqz   <= pz[sdp_pkg::SQ_W-1:0];
      self2 <= self1;
      last2 <= last1;
    end
    if (en[2]) begin
      sum   <= sdp_pkg::SUM_W'(sqx) + sdp_pkg::SUM_W'(sqy) + sdp_pkg::SUM_W'(sqz);
      self3 <= self2;
      last3 <= last2;
    end
    if (en[3]) begin
      dist_q.t    <= hit ? radius_sq - r2lo : '0;
      dist_q.last <= last3;
    end
  end

endmodule

[hw/rtl/sdp_kernel.sv]
// sdp_kernel: poly6 weight pipeline, kernel_coef * t^3 in fixed point with
// split partial products, capped to the accumulator range.
// Depends on sdp_pkg.
module sdp_kernel (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        dist_valid,
  output logic                        dist_ready,
  input  sdp_pkg::dist_t              dist_data,
  input  logic [sdp_pkg::CFG_W-1:0]   kernel_coef,
  output logic                        push,
  output sdp_pkg::entry_t             entry,
  input  logic                        full
);

  logic [4:0] v;
  logic [4:0] en;

  logic [2*sdp_pkg::CFG_W-1:0] tt;
  logic [sdp_pkg::CFG_W-1:0]   t1;
  logic [sdp_pkg::T2_W-1:0]    t2;
  logic [sdp_pkg::PP_W-1:0]    pl, ph, al, ah;
  logic [71:0]                 sum72;
  logic [sdp_pkg::T3_W-1:0]    t3;
  logic [sdp_pkg::PP_W:0]      wsum;
  logic [3:0]                  last_p;
  sdp_pkg::entry_t             entry_q;

  always_comb begin
    en[4] = !v[4] || !full;
    en[3] = !v[3] || en[4];
    en[2] = !v[2] || en[3];
    en[1] = !v[1] || en[2];
    en[0] = !v[0] || en[1];
  end

  assign dist_ready = en[0];
  assign push       = v[4] && !full;
  assign entry      = entry_q;

  assign tt    = dist_data.t * dist_data.t;
  assign sum72 = {ph, 16'b0} + 72'(pl);
  assign wsum  = (sdp_pkg::PP_W+1)'(ah) + (sdp_pkg::PP_W+1)'(al[sdp_pkg::PP_W-1:24]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= dist_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
      if (en[4]) v[4] <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t1        <= dist_data.t;
      t2        <= tt[2*sdp_pkg::CFG_W-1:24];
      last_p[0] <= dist_data.last;
    end
    if (en[1]) begin
      pl        <= t2 * t1[15:0];
      ph        <= t2 * t1[31:16];
      last_p[1] <= last_p[0];
    end
    if (en[2]) begin
      t3        <= sum72[71:24];
      last_p[2] <= last_p[1];
    end
    if (en[3]) begin
      al        <= t3[23:0] * kernel_coef;
      ah        <= t3[47:24] * kernel_coef;
      last_p[3] <= last_p[2];
    end
    if (en[4]) begin
      entry_q.w    <= (wsum > (sdp_pkg::PP_W+1)'(sdp_pkg::ACC_MAX)) ? sdp_pkg::ACC_MAX
                                                               : wsum[sdp_pkg::ACC_W-1:0];
      entry_q.last <= last_p[3];
    end
  end

endmodule

[hw/rtl/sdp_fifo.sv]
// sdp_fifo: short queue of weighted records between the kernel pipeline
// and the accumulator. Depends on sdp_pkg.
module sdp_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sdp_pkg::entry_t  din,
  output logic             full,
  input  logic             pop,
  output sdp_pkg::entry_t  dout,
  output logic             empty
);

  sdp_pkg::entry_t                  mem [sdp_pkg::FIFO_DEPTH];
  logic [sdp_pkg::FIFO_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [sdp_pkg::FIFO_CNT_W-1:0]   count;

  localparam logic [sdp_pkg::FIFO_PTR_W-1:0] PTR_LAST = sdp_pkg::FIFO_PTR_W'(sdp_pkg::FIFO_DEPTH - 1);
  localparam logic [sdp_pkg::FIFO_CNT_W-1:0] CNT_FULL = sdp_pkg::FIFO_CNT_W'(sdp_pkg::FIFO_DEPTH);

  assign full  = count == CNT_FULL;
  assign empty = count == '0;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

endmodule

[hw/rtl/sdp_back.sv]
// sdp_back: density accumulator and the pressure sequencer, one shared
// 24x32 multiplier for ratio, seventh power and stiffness, result register.
// Depends on sdp_pkg and sdp_ifs.
module sdp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  sdp_pkg::entry_t             head,
  input  logic                        empty,
  output logic                        pop,
  input  logic [sdp_pkg::CFG_W-1:0]   inv_rest_density,
  input  logic [sdp_pkg::CFG_W-1:0]   bulk_modulus,
  sdp_res_if.source                   res
);

  sdp_pkg::back_state_t           state, state_next;
  logic [sdp_pkg::STEP_W-1:0]     step, step_after;
  logic [sdp_pkg::ACC_W-1:0]      acc, acc_next;
  logic [sdp_pkg::ACC_W:0]        acc_sum;
  logic [sdp_pkg::CFG_W-1:0]      q;
  logic [sdp_pkg::PRES_W-1:0]     p, pres;
  logic [sdp_pkg::PP_W-1:0]       pl, ph;
  logic [79:0]                    prod;
  logic [sdp_pkg::PP_W-1:0]       prod_q24;
  logic [63:0]                    prod_q16;
  logic                           q_big;
  logic [sdp_pkg::PRES_W-1:0]     op_a;
  logic [sdp_pkg::CFG_W-1:0]      op_b;
  logic                           out_load, skip_pres;
  logic                           res_valid;
  logic [sdp_pkg::DENS_W-1:0]     dens_sat;

  assign acc_sum  = {1'b0, acc} + {1'b0, head.w};
  assign acc_next = acc_sum[sdp_pkg::ACC_W] ? sdp_pkg::ACC_MAX : acc_sum[sdp_pkg::ACC_W-1:0];

  assign prod     = {ph, 24'b0} + 80'(pl);
  assign prod_q24 = prod[79:24];
  assign prod_q16 = prod[79:16];
  assign q_big    = prod_q24[sdp_pkg::PP_W-1:sdp_pkg::CFG_W] != '0;
  assign dens_sat = (acc > sdp_pkg::ACC_W'(sdp_pkg::DENS_MAX)) ? sdp_pkg::DENS_MAX
                                                              : acc[sdp_pkg::DENS_W-1:0];

  // outputs of the sequencer
  always_comb begin
    pop       = (state == sdp_pkg::BK_ACC) && !empty;
    out_load  = (state == sdp_pkg::BK_OUT) && (!res_valid || res.ready);
    skip_pres = (state == sdp_pkg::BK_MUL_LO) && (step == sdp_pkg::STEP_PRES) &&
                (p <= sdp_pkg::ONE_Q24);
    priority if (step == sdp_pkg::STEP_RATIO) begin
      op_a = sdp_pkg::PRES_W'(acc);
      op_b = inv_rest_density;
    end else if (step == sdp_pkg::STEP_PRES) begin
      op_a = p - sdp_pkg::ONE_Q24;
      op_b = bulk_modulus;
    end else begin
      op_a = p;
      op_b = q;
    end
    step_after = (step == sdp_pkg::STEP_RATIO && q_big) ? sdp_pkg::STEP_PRES
                                                        : step + sdp_pkg::STEP_W'(1);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sdp_pkg::BK_ACC:     if (pop && head.last) state_next = sdp_pkg::BK_MUL_LO;
      sdp_pkg::BK_MUL_LO:  state_next = skip_pres ? sdp_pkg::BK_OUT : sdp_pkg::BK_MUL_HI;
      sdp_pkg::BK_MUL_HI:  state_next = sdp_pkg::BK_MUL_SUM;
      sdp_pkg::BK_MUL_SUM: state_next = (step == sdp_pkg::STEP_PRES) ? sdp_pkg::BK_OUT
                                                                     : sdp_pkg::BK_MUL_LO;
      sdp_pkg::BK_OUT:     if (out_load) state_next = sdp_pkg::BK_ACC;
      default:             state_next = sdp_pkg::BK_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sdp_pkg::BK_ACC;
      step      <= sdp_pkg::STEP_RATIO;
      acc       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) acc <= acc_next;
      if (out_load) acc <= '0;
      if (pop && head.last) step <= sdp_pkg::STEP_RATIO;
      if (state == sdp_pkg::BK_MUL_SUM) step <= step_after;
      if (out_load) res_valid <= 1'b1;
      else if (res.ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sdp_pkg::BK_MUL_LO) pl <= op_a[23:0] * op_b;
    if (state == sdp_pkg::BK_MUL_HI) ph <= op_a[47:24] * op_b;
    if (skip_pres) pres <= '0;
    if (state == sdp_pkg::BK_MUL_SUM) begin
      if (step == sdp_pkg::STEP_RATIO) begin
        q <= prod_q24[sdp_pkg::CFG_W-1:0];
        p <= q_big ? sdp_pkg::PRES_MAX : prod_q24[sdp_pkg::PRES_W-1:0];
      end else if (step == sdp_pkg::STEP_PRES) begin
        pres <= (prod_q16 > 64'(sdp_pkg::PRES_MAX)) ? sdp_pkg::PRES_MAX
                                                    : prod_q16[sdp_pkg::PRES_W-1:0];
      end else begin
        p <= (prod_q24 > sdp_pkg::PP_W'(sdp_pkg::PRES_MAX)) ? sdp_pkg::PRES_MAX
                                                           : prod_q24[sdp_pkg::PRES_W-1:0];
      end
    end
    if (out_load) begin
      res.density  <= (dens_sat < sdp_pkg::DENS_FLOOR) ? sdp_pkg::DENS_FLOOR : dens_sat;
      res.pressure <= (pres < sdp_pkg::PRES_FLOOR) ? sdp_pkg::PRES_FLOOR : pres;
    end
  end

  assign res.valid = res_valid;

endmodule

[hw/rtl/sph_density_pressure_core.sv]
// SPH density and Tait pressure core. Neighbor records of one particle are
// taken one per cycle while the queue has room; a 4-stage front (differences,
// squares, sum, range test) and a 5-stage poly6 weight pipeline feed a
// 4-entry queue ahead of a saturating accumulator, so a run of records
// streams at one per cycle while the back end accumulates. On the record
// marked last the back end computes ratio, seventh power and pressure on
// one shared 24x32 multiplier, each product in a low half, high half and sum;
// the pressure product is skipped when the seventh power is at most one, the
// powers when the ratio overflows. Meanwhile the queue and the pipelines keep
// taking records until the queue fills. A result waits in an output register
// without blocking the records of the next particle. Register writes are
// taken at any time and must only be made while the block is idle.
module sph_density_pressure_core (
  input  logic        clk,
  input  logic        rst,
  sdp_rec_if.sink     rec,
  sdp_res_if.source   res,
  sdp_cfg_if.sink     cfg
);

  logic [sdp_pkg::CFG_W-1:0] radius_sq;
  logic [sdp_pkg::CFG_W-1:0] kernel_coef;
  logic [sdp_pkg::CFG_W-1:0] inv_rest_density;
  logic [sdp_pkg::CFG_W-1:0] bulk_modulus;

  logic             dist_valid, dist_ready;
  sdp_pkg::dist_t   dist_data;
  logic             push, full, pop, empty;
  sdp_pkg::entry_t  entry, head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_sq        <= sdp_pkg::RADIUS_SQ_RST;
      kernel_coef      <= sdp_pkg::KERNEL_COEF_RST;
      inv_rest_density <= sdp_pkg::INV_REST_DENSITY_RST;
      bulk_modulus     <= sdp_pkg::BULK_MODULUS_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        sdp_pkg::REG_RADIUS_SQ:        radius_sq        <= cfg.data;
        sdp_pkg::REG_KERNEL_COEF:      kernel_coef      <= cfg.data;
        sdp_pkg::REG_INV_REST_DENSITY: inv_rest_density <= cfg.data;
        sdp_pkg::REG_BULK_MODULUS:     bulk_modulus     <= cfg.data;
        default: ;
      endcase
    end
  end

  sdp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rec        (rec),
    .radius_sq  (radius_sq),
    .dist_valid (dist_valid),
    .dist_ready (dist_ready),
    .dist_data  (dist_data)
  );

  sdp_kernel u_kernel (
    .clk         (clk),
    .rst         (rst),
    .dist_valid  (dist_valid),
    .dist_ready  (dist_ready),
    .dist_data   (dist_data),
    .kernel_coef (kernel_coef),
    .push        (push),
    .entry       (entry),
    .full        (full)
  );

  sdp_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (entry),
    .full  (full),
    .pop   (pop),
    .dout  (head),
    .empty (empty)
  );

  sdp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .empty            (empty),
    .pop              (pop),
    .inv_rest_density (inv_rest_density),
    .bulk_modulus     (bulk_modulus),
    .res              (res)
  );

endmodule

[hw/rtl/sdp_checker.sv]
// sdp_checker: port-level assertions for sph_density_pressure_core, bound
// to the top level below. Depends on sdp_pkg.
module sdp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         rec_valid,
  input logic                         rec_ready,
  input logic                         rec_last,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [sdp_pkg::DENS_W-1:0]   density,
  input logic [sdp_pkg::PRES_W-1:0]   pressure
);

  // particles whose last request was taken but whose result is not yet out
  logic [7:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 8'(rec_valid && rec_ready && rec_last)
                         - 8'(res_valid && res_ready);
    end
  end

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(density) && $stable(pressure))
    else $error("result changed while stalled");

  a_res_needs_last: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pending != 8'd0)
    else $error("result without a pending last request");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result shown right after reset");

  a_floors: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> density >= sdp_pkg::DENS_FLOOR && pressure >= sdp_pkg::PRES_FLOOR)
    else $error("result below floor");

endmodule

bind sph_density_pressure_core sdp_checker u_sdp_checker (
  .clk       (clk),
  .rst       (rst),
  .rec_valid (rec.valid),
  .rec_ready (rec.ready),
  .rec_last  (rec.last),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .density   (res.density),
  .pressure  (res.pressure)
);

[dv/sdp_density_checker.sv]
`timescale 1ns / 100ps
// sdp_density_checker: watches the record, result and register write channels of
// sph_density_pressure_core, predicts density and pressure per particle and compares.
// Depends on sdp_pkg and the channel interfaces in sdp_ifs.
module sdp_density_checker
  import sdp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  sdp_rec_if   rec,
  sdp_res_if   res,
  sdp_cfg_if   cfg,
  output int   fail_count,
  output int   pending
);

  localparam logic [63:0] ACC_LIMIT = 64'(ACC_MAX);
  localparam logic [63:0] POW_CAP   = (64'd1 << 48) - 64'd1;
  localparam logic [63:0] RATIO_LIM = 64'd1 << 32;

  typedef struct packed {
    logic [DENS_W-1:0] density;
    logic [PRES_W-1:0] pressure;
  } dens_pres_t;

  dens_pres_t       dens_pres_q[$];
  logic [CFG_W-1:0] radius_sq_r;
  logic [CFG_W-1:0] kernel_coef_r;
  logic [CFG_W-1:0] inv_rest_r;
  logic [CFG_W-1:0] bulk_r;
  logic [63:0]      density_sum;
  int               errors;

  function automatic logic [63:0] mul_floor(input logic [63:0] a, input logic [31:0] b,
                                            input int unsigned sh);
    logic [95:0] prod;
    prod = {32'd0, a} * {64'd0, b};
    return 64'(prod >> sh);
  endfunction

  always @(posedge clk) begin
    longint      dx, dy, dz;
    logic [63:0] r2, t, t2, t3, w, q, p, pres, dens;
    dens_pres_t  want;
    if (rst) begin
      radius_sq_r   = RADIUS_SQ_RST;
      kernel_coef_r = KERNEL_COEF_RST;
      inv_rest_r    = INV_REST_DENSITY_RST;
      bulk_r        = BULK_MODULUS_RST;
      density_sum   = '0;
      dens_pres_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (dens_pres_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result density %0d pressure %0d", $time,
                   res.density, res.pressure);
        end else begin
          want = dens_pres_q.pop_front();
          if (res.density !== want.density) begin
            errors++;
            $display("%0t: density expected %0d actual %0d", $time, want.density,
                     res.density);
          end
          if (res.pressure !== want.pressure) begin
            errors++;
            $display("%0t: pressure expected %0d actual %0d", $time, want.pressure,
                     res.pressure);
          end
        end
      end

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_RADIUS_SQ:        radius_sq_r   = cfg.data;
          REG_KERNEL_COEF:      kernel_coef_r = cfg.data;
          REG_INV_REST_DENSITY: inv_rest_r    = cfg.data;
          REG_BULK_MODULUS:     bulk_r        = cfg.data;
          default: ;
        endcase
      end

      if (rec.valid && rec.ready) begin
        if (!rec.is_self) begin
          dx = longint'(rec.center_x) - longint'(rec.neighbor_x);
          dy = longint'(rec.center_y) - longint'(rec.neighbor_y);
          dz = longint'(rec.center_z) - longint'(rec.neighbor_z);
          r2 = 64'(dx * dx + dy * dy + dz * dz);
          r2 = (r2 >> SHR) << SHL;
          if (r2 < 64'(radius_sq_r)) begin
            t  = 64'(radius_sq_r) - r2;
            t2 = mul_floor(t, t[31:0], 24);
            t3 = mul_floor(t2, t[31:0], 24);
            w  = mul_floor(t3, kernel_coef_r, 24);
            if (w > ACC_LIMIT) w = ACC_LIMIT;
            density_sum = density_sum + w;
            if (density_sum > ACC_LIMIT) density_sum = ACC_LIMIT;
          end
        end
        // a request with last set closes the particle
        if (rec.last) begin
          q = mul_floor(density_sum, inv_rest_r, 24);
          if (q >= RATIO_LIM) begin
            p = POW_CAP;
          end else begin
            p = q;
            repeat (POW_EXP - 1) begin
              p = mul_floor(p, q[31:0], 24);
              if (p > POW_CAP) p = POW_CAP;
            end
          end
          if (p <= 64'(ONE_Q24)) begin
            pres = '0;
          end else begin
            pres = mul_floor(p - 64'(ONE_Q24), bulk_r, 16);
            if (pres > 64'(PRES_MAX)) pres = 64'(PRES_MAX);
          end
          if (pres < 64'(PRES_FLOOR)) pres = 64'(PRES_FLOOR);
          dens = (density_sum > 64'(DENS_MAX)) ? 64'(DENS_MAX) : density_sum;
          if (dens < 64'(DENS_FLOOR)) dens = 64'(DENS_FLOOR);
          want.density  = dens[DENS_W-1:0];
          want.pressure = pres[PRES_W-1:0];
          dens_pres_q.insert(dens_pres_q.size(), want);
          density_sum = '0;
        end
      end
    end
    fail_count <= errors;
    pending    <= dens_pres_q.size();
  end

endmodule

[dv/sph_density_pressure_core_test.sv]
`timescale 1ns / 100ps
// sph_density_pressure_core_test: drives neighbor record streams and register writes
// into sph_density_pressure_core under several idle patterns and gives the verdict.
// Depends on sdp_pkg, sdp_ifs, the core and sdp_density_checker.
module sph_density_pressure_core_test;
  import sdp_pkg::*;

  localparam int PHASES        = 8;
  localparam int PHASE_RECORDS = 210;
  localparam int SETTLE_CYCLES = 64;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int UNIT          = 1 << POS_FRAC;
  localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};
  localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};

  logic clk;
  logic rst;
  int   send_idle;
  int   recv_stall;
  int   cycles;
  int   fail_count;
  int   pending;

  sdp_rec_if rec_bus ();
  sdp_res_if res_bus ();
  sdp_cfg_if cfg_bus ();

  sph_density_pressure_core uut (
    .clk (clk),
    .rst (rst),
    .rec (rec_bus),
    .res (res_bus),
    .cfg (cfg_bus)
  );

  sdp_density_checker result_chk (
    .clk        (clk),
    .rst        (rst),
    .rec        (rec_bus),
    .res        (res_bus),
    .cfg        (cfg_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    res_bus.ready <= !rst && ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int pos_offset(input int span);
    int mag;
    mag = int'($urandom_range(0, (1 << span) - 1));
    return $urandom_range(1) ? mag : -mag;
  endfunction

  task automatic send_record(input logic signed [POS_WIDTH-1:0] cx, cy, cz, nx, ny, nz,
                             input logic self_rec, input logic last_rec);
    rec_bus.valid      <= 1'b1;
    rec_bus.center_x   <= cx;
    rec_bus.center_y   <= cy;
    rec_bus.center_z   <= cz;
    rec_bus.neighbor_x <= nx;
    rec_bus.neighbor_y <= ny;
    rec_bus.neighbor_z <= nz;
    rec_bus.is_self    <= self_rec;
    rec_bus.last       <= last_rec;
    do @(posedge clk); while (!rec_bus.ready);
    if ($urandom_range(99) < send_idle) begin
      rec_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  task automatic configure(input logic [CFG_W-1:0] radius, kernel, inv_rest, bulk);
    cfg_write(REG_RADIUS_SQ, radius);
    cfg_write(REG_KERNEL_COEF, kernel);
    cfg_write(REG_INV_REST_DENSITY, inv_rest);
    cfg_write(REG_BULK_MODULUS, bulk);
    // unmapped index, must leave every register alone
    cfg_write(REG_BULK_MODULUS + CFG_IDX_W'($urandom_range(1, 252)), $urandom);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    rec_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic signed [POS_WIDTH-1:0] cx, cy, cz, nx, ny, nz;
    int   count;
    int   span;
    int   sent;
    logic noise;

    rst                = 1'b1;
    rec_bus.valid      = 1'b0;
    rec_bus.center_x   = '0;
    rec_bus.center_y   = '0;
    rec_bus.center_z   = '0;
    rec_bus.neighbor_x = '0;
    rec_bus.neighbor_y = '0;
    rec_bus.neighbor_z = '0;
    rec_bus.is_self    = 1'b0;
    rec_bus.last       = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = '0;
    cfg_bus.data       = '0;
    send_idle          = 0;
    recv_stall         = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty list, coincident neighbor, radius boundary and just inside
    send_record('0, '0, '0, '0, '0, '0, 1'b1, 1'b1);
    send_record('0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
    send_record('0, '0, '0, POS_WIDTH'(UNIT), '0, '0, 1'b0, 1'b1);
    send_record('0, '0, '0, POS_WIDTH'(UNIT - 1), '0, '0, 1'b0, 1'b0);
    send_record(POS_WIDTH'(100), POS_WIDTH'(-200), POS_WIDTH'(300),
                POS_WIDTH'(100), POS_WIDTH'(-200), POS_WIDTH'(300), 1'b1, 1'b1);
    // position extremes
    send_record(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX, 1'b0, 1'b0);
    send_record(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN, 1'b0, 1'b0);
    send_record(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 1'b0, 1'b0);
    send_record(POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, 1'b0, 1'b0);
    send_record('1, '1, '1, '0, '0, '0, 1'b0, 1'b0);
    send_record(POS_MIN, POS_MAX, '0, POS_MIN, POS_MAX, '0, 1'b1, 1'b0);
    send_record('0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
    for (int k = 0; k < 10; k++) begin
      send_record('0, '0, '0, POS_WIDTH'(300 * k), POS_WIDTH'(-200 * k),
                  POS_WIDTH'(100 * k), 1'b0, k == 9);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: configure('1, '1, '1, '1);
        1: configure('0, '0, '0, '0);
        2: configure(RADIUS_SQ_RST, 32'h0100_0000, 32'h0100_0000, $urandom);
        default: configure($urandom >> $urandom_range(0, 12),
                           $urandom >> $urandom_range(0, 24),
                           $urandom >> $urandom_range(0, 24),
                           $urandom >> $urandom_range(0, 31));
      endcase
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall <= 0;  end
        1: begin send_idle = 82; recv_stall <= 0;  end
        2: begin send_idle = 0;  recv_stall <= 82; end
        default: begin send_idle = 15; recv_stall <= 15; end
      endcase

      sent = 0;
      while (sent < PHASE_RECORDS) begin
        count = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        noise = ($urandom_range(9) == 0);
        span  = $urandom_range(0, POS_WIDTH - 1);
        cx    = POS_WIDTH'($urandom);
        cy    = POS_WIDTH'($urandom);
        cz    = POS_WIDTH'($urandom);
        for (int k = 0; k < count; k++) begin
          if (noise) begin
            cx = POS_WIDTH'($urandom);
            cy = POS_WIDTH'($urandom);
            cz = POS_WIDTH'($urandom);
            nx = POS_WIDTH'($urandom);
            ny = POS_WIDTH'($urandom);
            nz = POS_WIDTH'($urandom);
            send_record(cx, cy, cz, nx, ny, nz, 1'($urandom_range(1)),
                        (k == count - 1) || ($urandom_range(3) == 0));
          end else begin
            nx = POS_WIDTH'(int'(cx) + pos_offset(span));
            ny = POS_WIDTH'(int'(cy) + pos_offset(span));
            nz = POS_WIDTH'(int'(cz) + pos_offset(span));
            send_record(cx, cy, cz, nx, ny, nz, $urandom_range(7) == 0, k == count - 1);
          end
          sent++;
        end
      end
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
